FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define SKVT_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SKVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/skvt_pkg.sv
package skvt_pkg;

  localparam int DEPTH       = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int ENTRY_WIDTH = KEY_WIDTH + VALUE_WIDTH;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_ERASE  = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_KEY_PRESENT = 2'd1,
    ST_FULL        = 2'd2,
    ST_NOT_FOUND   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_APPEND,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] req_key;
    logic [31:0] req_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [4:0]  entry_count;
  } rsp_t;

endpackage

FILE: rtl/small_key_value_table.sv
// channel | dir | handshake         | word
// req     | in  | req_valid/stall   | req_type, req_key, req_value
// rsp     | out | rsp_valid/stall   | status, value_out, entry_count
//
// One request at a time. A scan visits each stored entry in turn: it reads the
// entry from the RAM, then compares it against the request.
// Erase compacts in place during the scan: the write pointer trails the read.
// rst clears the entry count and control; the pair RAM is never cleared.
// A result waiting on rsp_stall does not block the next request.
`include "assert_macros.svh"

module small_key_value_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  skvt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output skvt_pkg::rsp_t rsp
);

  import skvt_pkg::*;

  state_t                 state, state_next;
  req_t                   cur, cur_next;
  logic [IDX_W-1:0]       idx, idx_next;
  logic [CNT_W-1:0]       wcnt, wcnt_next;
  logic [CNT_W-1:0]       fill, fill_next;
  status_t                status, status_next;
  logic [31:0]            found, found_next;
  logic                   rsp_valid_next;
  rsp_t                   rsp_next;

  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [ENTRY_WIDTH-1:0] mem_wdata;
  logic [ENTRY_WIDTH-1:0] mem_rdata;

  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic                   last;
  logic                   keep;
  logic [CNT_W-1:0]       keep_cnt;

  skvt_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx),
    .rdata (mem_rdata)
  );

  assign rd_key    = mem_rdata[ENTRY_WIDTH-1:VALUE_WIDTH];
  assign rd_val    = mem_rdata[VALUE_WIDTH-1:0];
  assign last      = (CNT_W'(idx) == (fill - CNT_W'(1)));
  assign keep      = (rd_val != cur.req_value[VALUE_WIDTH-1:0]);
  assign keep_cnt  = wcnt + CNT_W'(keep);
  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      rsp_valid <= rsp_valid_next;
    end
    cur      <= cur_next;
    idx      <= idx_next;
    wcnt     <= wcnt_next;
    status   <= status_next;
    found    <= found_next;
    rsp      <= rsp_next;
  end

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    idx_next       = idx;
    wcnt_next      = wcnt;
    fill_next      = fill;
    status_next    = status;
    found_next     = found;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cur_next    = req;
          idx_next    = '0;
          wcnt_next   = '0;
          found_next  = '0;
          status_next = ST_NOT_FOUND;
          unique case (req.req_type) inside
            REQ_INSERT: state_next = (fill == '0) ? S_APPEND : S_READ;
            REQ_LOOKUP,
            REQ_ERASE:  state_next = (fill == '0) ? S_RESULT : S_READ;
            default:    state_next = S_RESULT;
          endcase
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        unique case (cur.req_type)
          REQ_INSERT: begin
            if (rd_key == cur.req_key[KEY_WIDTH-1:0]) begin
              status_next = ST_KEY_PRESENT;
              state_next  = S_RESULT;
            end else if (last) begin
              state_next = S_APPEND;
            end else begin
              idx_next   = idx + IDX_W'(1);
              state_next = S_READ;
            end
          end
          REQ_LOOKUP: begin
            if (rd_key == cur.req_key[KEY_WIDTH-1:0]) begin
              found_next  = 32'(rd_val);
              status_next = ST_DONE;
              state_next  = S_RESULT;
            end else if (last) begin
              state_next = S_RESULT;
            end else begin
              idx_next   = idx + IDX_W'(1);
              state_next = S_READ;
            end
          end
          REQ_ERASE: begin
            if (keep && (wcnt != CNT_W'(idx))) begin
              mem_we    = 1'b1;
              mem_waddr = wcnt[IDX_W-1:0];
              mem_wdata = mem_rdata;
            end
            wcnt_next = keep_cnt;
            if (last) begin
              fill_next   = keep_cnt;
              status_next = (keep_cnt != fill) ? ST_DONE : ST_NOT_FOUND;
              state_next  = S_RESULT;
            end else begin
              idx_next   = idx + IDX_W'(1);
              state_next = S_READ;
            end
          end
          default: state_next = S_RESULT;
        endcase
      end
      S_APPEND: begin
        if (fill >= CNT_W'(DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          mem_we      = 1'b1;
          mem_waddr   = fill[IDX_W-1:0];
          mem_wdata   = {cur.req_key[KEY_WIDTH-1:0], cur.req_value[VALUE_WIDTH-1:0]};
          fill_next   = fill + CNT_W'(1);
          status_next = ST_DONE;
        end
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next       = 1'b1;
          rsp_next.status      = status;
          rsp_next.value_out   = found;
          rsp_next.entry_count = 5'(fill);
          state_next           = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `SKVT_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
    "request accepted but block not busy next cycle")
  `SKVT_ASSERT_IMPLIES(a_compact_trails_scan, (state == S_CHECK) && mem_we,
    wcnt < CNT_W'(idx), "compaction write not behind scan pointer")
  `SKVT_ASSERT_IMPLIES(a_append_has_room, (state == S_APPEND) && mem_we,
    fill < CNT_W'(DEPTH), "append into full table")

endmodule

FILE: rtl/skvt_ram.sv
module skvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
